@@ sv/assert_macros.svh @@
// assertion macros shared by the queue rtl
// no dependencies; define SYNTH to drop all checks from synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every edge out of reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen out of reset
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, cond, msg)
`endif
`endif

@@ sv/spq_pkg.sv @@
// shared types and constants for the sorted insert priority queue
// used by spq_cell, sorted_insert_priority_queue and tb_top
package spq_pkg;

  // default sizes
  localparam int DEPTH_DEF        = 128;
  localparam int KEY_BITS_DEF     = 16;
  localparam int PAYLOAD_BITS_DEF = 16;

  // fixed result field widths
  localparam int STATUS_BITS = 2;
  localparam int FILL_BITS   = 8;

  // operation codes on the input beat
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert beat that fits
    logic rem;  // remove beat on a non-empty queue
  } spq_ctl_t;

endpackage

@@ sv/spq_cell.sv @@
// one slot of the sorted shift-register queue
// depends on spq_pkg for the command struct
module spq_cell import spq_pkg::*; #(
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  parameter int CNT_BITS     = 8,
  parameter int IDX          = 0
) (
  input  logic                    clk,
  input  spq_ctl_t                ctl,
  input  logic [CNT_BITS-1:0]     count,
  input  logic [KEY_BITS-1:0]     new_key,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic [KEY_BITS-1:0]     left_key,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic                    left_back,
  input  logic [KEY_BITS-1:0]     right_key,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  output logic [KEY_BITS-1:0]     key,
  output logic [PAYLOAD_BITS-1:0] payload,
  output logic                    back
);

  logic occ;
  logic at_tail;

  // slot is held when below the fill count; tail is the first free slot
  assign occ     = CNT_BITS'(IDX) < count;
  assign at_tail = CNT_BITS'(IDX) == count;

  // held entry moves back when the new key is strictly smaller
  assign back = occ && (new_key < key);

  // load from left neighbor, new beat or right neighbor
  always_ff @(posedge clk) begin
    if (ctl.ins && (back || at_tail)) begin
      if (left_back) begin
        key     <= left_key;
        payload <= left_payload;
      end else begin
        key     <= new_key;
        payload <= new_payload;
      end
    end else if (ctl.rem) begin
      key     <= right_key;
      payload <= right_payload;
    end
  end

endmodule

@@ sv/sorted_insert_priority_queue.sv @@
// top level of the sorted insert priority queue: cell chain, fill count, output register
// depends on spq_pkg, spq_cell and assert_macros.svh
//
// channel  dir  tdata (low bit up)               tuser
// s_axis   in   key, payload, zero pad           func
// m_axis   out  out_key, out_payload, fill, pad  status
//
// one beat per cycle while s_axis_tready is high; every accepted beat yields one result beat in the cycle after it
// a chain of DEPTH cells updates the slots that move in the accepting cycle
// the single output register is refilled in the cycle it is drained
// reset clears the fill count and the output valid; slot contents need none
// s_axis_tready is low during reset and while an unread result waits on m_axis_tready
`include "assert_macros.svh"
module sorted_insert_priority_queue import spq_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int IN_BITS     = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
  localparam int OUT_BITS    = ((KEY_BITS + PAYLOAD_BITS + FILL_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_BITS-1:0]     s_axis_tdata,  // key, payload, zero pad
  input  logic                   s_axis_tuser,  // func
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_BITS-1:0]    m_axis_tdata,  // out_key, out_payload, fill, zero pad
  output logic [STATUS_BITS-1:0] m_axis_tuser   // status
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [CNT_BITS-1:0]     count;
  logic [CNT_BITS-1:0]     count_next;
  logic                    in_acc;
  logic                    is_full;
  logic                    is_empty;
  spq_ctl_t                ctl;
  logic [KEY_BITS-1:0]     in_key;
  logic [PAYLOAD_BITS-1:0] in_payload;
  logic [STATUS_BITS-1:0]  status_next;

  logic [KEY_BITS-1:0]     cell_key     [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
  logic                    cell_back    [DEPTH];

  logic                    out_valid;
  logic [OUT_BITS-1:0]     out_data;
  logic [STATUS_BITS-1:0]  out_status;

  // input beat fields
  assign in_key     = s_axis_tdata[KEY_BITS-1:0];
  assign in_payload = s_axis_tdata[KEY_BITS +: PAYLOAD_BITS];

  // accept out of reset whenever the output register is free or draining
  assign s_axis_tready = !rst && (!out_valid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign is_full  = count == CNT_BITS'(DEPTH);
  assign is_empty = count == '0;

  // command to the chain
  assign ctl.ins = in_acc && (s_axis_tuser == FUNC_INSERT) && !is_full;
  assign ctl.rem = in_acc && (s_axis_tuser == FUNC_REMOVE) && !is_empty;

  // fill count and status
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    if (s_axis_tuser == FUNC_INSERT) begin
      if (is_full) status_next = ST_FULL;
    end else begin
      if (is_empty) status_next = ST_EMPTY;
    end
    if (ctl.ins) begin
      count_next = count + 1'b1;
    end else if (ctl.rem) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // chain of slots, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]     l_key;
    logic [PAYLOAD_BITS-1:0] l_payload;
    logic                    l_back;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;

    if (i == 0) begin : g_head
      assign l_key     = '0;
      assign l_payload = '0;
      assign l_back    = 1'b0;
    end else begin : g_mid
      assign l_key     = cell_key[i-1];
      assign l_payload = cell_payload[i-1];
      assign l_back    = cell_back[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_key     = '0;
      assign r_payload = '0;
    end else begin : g_inner
      assign r_key     = cell_key[i+1];
      assign r_payload = cell_payload[i+1];
    end

    spq_cell #(
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .CNT_BITS     (CNT_BITS),
      .IDX          (i)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .count         (count),
      .new_key       (in_key),
      .new_payload   (in_payload),
      .left_key      (l_key),
      .left_payload  (l_payload),
      .left_back     (l_back),
      .right_key     (r_key),
      .right_payload (r_payload),
      .key           (cell_key[i]),
      .payload       (cell_payload[i]),
      .back          (cell_back[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status <= status_next;
      if (ctl.rem) begin
        out_data <= OUT_BITS'({FILL_BITS'(count_next), cell_payload[0], cell_key[0]});
      end else begin
        out_data <= OUT_BITS'({FILL_BITS'(count_next), PAYLOAD_BITS'(0), KEY_BITS'(0)});
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;

  // checks
  `ASSERT_NEVER(a_count_range, clk, rst, count > CNT_BITS'(DEPTH), "fill count above depth")
  `ASSERT_CLK(a_rem_dec, clk, rst, ctl.rem |=> count == $past(count) - 1'b1, "no shrink")
  `ASSERT_CLK(a_full_flag, clk, rst, (out_valid && out_status == ST_FULL) |-> is_full, "bad full")
  `ASSERT_CLK(a_head, clk, rst, count > CNT_BITS'(1) |-> cell_key[0] <= cell_key[1], "unsorted")

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for sorted_insert_priority_queue: directed, full-queue and random tests
// keeps its own sorted shadow of the queue and checks every result beat against it
// depends on spq_pkg and the rtl of the queue
module tb_top;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH     = 128;
  localparam int KEY_W      = 16;
  localparam int PAY_W      = 16;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 40;
  localparam int CYCLE_CAP  = 200000;
  localparam int IDLE_PCT   = 13;
  localparam int MAX_REPORT = 10;

  // one expected result beat
  typedef struct {
    logic [STATUS_BITS-1:0] status;
    logic [KEY_W-1:0]       key;
    logic [PAY_W-1:0]       payload;
    logic [FILL_BITS-1:0]   fill;
  } queue_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata = '0;  // key, payload
  logic                   s_axis_tuser = FUNC_INSERT;  // func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_W-1:0]       m_axis_tdata;  // out_key, out_payload, fill
  logic [STATUS_BITS-1:0] m_axis_tuser;  // status

  // shadow of the sorted queue contents
  logic [KEY_W-1:0] shadow_keys [QDEPTH];
  logic [PAY_W-1:0] shadow_payloads [QDEPTH];
  int               shadow_count = 0;

  queue_result_t pending_results[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  logic          calm = 1'b0;  // no idling on either side while set

  sorted_insert_priority_queue dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // apply one operation to the shadow queue and return its result
  function automatic queue_result_t apply_queue_op(input logic func, input logic [KEY_W-1:0] key,
                                                   input logic [PAY_W-1:0] payload);
    queue_result_t r;
    int i;
    r.status  = ST_OK;
    r.key     = '0;
    r.payload = '0;
    if (func == FUNC_INSERT) begin
      if (shadow_count >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        // equal keys stay ahead of the new entry
        i = shadow_count;
        while (i > 0 && key < shadow_keys[i-1]) begin
          shadow_keys[i]     = shadow_keys[i-1];
          shadow_payloads[i] = shadow_payloads[i-1];
          i--;
        end
        shadow_keys[i]     = key;
        shadow_payloads[i] = payload;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key     = shadow_keys[0];
        r.payload = shadow_payloads[0];
        shadow_count--;
        for (i = 0; i < shadow_count; i++) begin
          shadow_keys[i]     = shadow_keys[i+1];
          shadow_payloads[i] = shadow_payloads[i+1];
        end
      end
    end
    r.fill = shadow_count[FILL_BITS-1:0];
    return r;
  endfunction

  // send one beat, with random gaps ahead of it, and record its expected result
  task automatic send_beat(input logic func, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] payload);
    queue_result_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {payload, key};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = apply_queue_op(func, key, payload);
    pending_results.push_back(r);
  endtask

  // result sink: random backpressure and compare against the oldest expectation
  always @(posedge clk) begin
    queue_result_t want;
    logic [KEY_W-1:0] got_key;
    logic [PAY_W-1:0] got_pay;
    logic [FILL_BITS-1:0] got_fill;
    got_key  = m_axis_tdata[KEY_W-1:0];
    got_pay  = m_axis_tdata[KEY_W+PAY_W-1:KEY_W];
    got_fill = m_axis_tdata[KEY_W+PAY_W+FILL_BITS-1:KEY_W+PAY_W];
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORT)
          $display("unexpected result beat: status %0d key %h payload %h fill %0d",
                   m_axis_tuser, got_key, got_pay, got_fill);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status || got_key !== want.key ||
            got_pay !== want.payload || got_fill !== want.fill) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORT)
            $display("mismatch: status %0d/%0d key %h/%h payload %h/%h fill %0d/%0d (exp/act)",
                     want.status, m_axis_tuser, want.key, got_key,
                     want.payload, got_pay, want.fill, got_fill);
        end
      end
    end
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // key draw that mixes the full range with two narrow ones, at the low and the top end, to force ties
  function automatic logic [KEY_W-1:0] draw_key();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return KEY_W'($urandom_range(7));
    if (sel == 4) return {KEY_W{1'b1}} - KEY_W'($urandom_range(3));
    return KEY_W'($urandom);
  endfunction

  // remove on an empty queue straight out of reset
  task automatic test_empty_after_reset();
    send_beat(FUNC_REMOVE, '0, '0);
    send_beat(FUNC_REMOVE, {KEY_W{1'b1}}, {PAY_W{1'b1}});
  endtask

  // field extremes, ties and back to back insert/remove
  task automatic test_extremes_and_ties();
    send_beat(FUNC_INSERT, 16'hffff, 16'h0000);
    send_beat(FUNC_INSERT, 16'h0000, 16'hffff);
    send_beat(FUNC_INSERT, 16'h1000, 16'h0001);
    send_beat(FUNC_INSERT, 16'h1000, 16'h0002);
    send_beat(FUNC_INSERT, 16'h1000, 16'h0003);
    send_beat(FUNC_INSERT, 16'h0000, 16'h0005);
    send_beat(FUNC_INSERT, 16'hffff, 16'haaaa);
    repeat (8) send_beat(FUNC_REMOVE, 16'h5555, 16'haaaa);
    send_beat(FUNC_INSERT, 16'h8001, 16'h7ffe);
    send_beat(FUNC_REMOVE, '0, '0);
    send_beat(FUNC_INSERT, 16'h7ffe, 16'h8001);
    send_beat(FUNC_REMOVE, '0, '0);
    send_beat(FUNC_REMOVE, '0, '0);
  endtask

  // fill to capacity, push on full, then drain past empty
  task automatic test_full_queue();
    repeat (QDEPTH) send_beat(FUNC_INSERT, draw_key(), PAY_W'($urandom));
    send_beat(FUNC_INSERT, '0, PAY_W'($urandom));
    send_beat(FUNC_INSERT, {KEY_W{1'b1}}, PAY_W'($urandom));
    send_beat(FUNC_REMOVE, KEY_W'($urandom), PAY_W'($urandom));
    send_beat(FUNC_INSERT, draw_key(), PAY_W'($urandom));
    send_beat(FUNC_INSERT, draw_key(), PAY_W'($urandom));
    repeat (QDEPTH + 2) send_beat(FUNC_REMOVE, KEY_W'($urandom), PAY_W'($urandom));
  endtask

  // random mix in chunks with varying insert bias, one chunk without idling
  task automatic test_random_mix();
    int unsigned ins_pct;
    int chunk;
    for (chunk = 0; chunk < 7; chunk++) begin
      case (chunk % 3)
        0: ins_pct = 80;
        1: ins_pct = 50;
        default: ins_pct = 25;
      endcase
      calm <= (chunk == 3);
      repeat (60) begin
        if ($urandom_range(99) < ins_pct)
          send_beat(FUNC_INSERT, draw_key(), PAY_W'($urandom));
        else
          send_beat(FUNC_REMOVE, KEY_W'($urandom), PAY_W'($urandom));
      end
    end
    calm <= 1'b0;
  endtask

  // test sequence and final verdict
  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_after_reset();
    test_extremes_and_ties();
    test_full_queue();
    test_random_mix();
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
